FILE: design/cls_pkg.sv
// ----------------------------------------------------------------------------
// cls_pkg
// Types and constants for the colored Life stencil step.
// ----------------------------------------------------------------------------
`default_nettype none

package cls_pkg;

  localparam int unsigned TileBits = 8;
  localparam int unsigned SumBits  = TileBits + 3;
  localparam int unsigned CntBits  = 4;
  localparam int unsigned FillBits = 2;

  // floor(x / 3) == (x * Recip3) >> SumBits for every x below 2**SumBits
  localparam int unsigned RecipBits = SumBits;
  localparam logic [RecipBits-1:0] Recip3 = RecipBits'(((1 << SumBits) + 2) / 3);

  localparam logic [FillBits-1:0] FillFull = FillBits'(2);

  typedef logic [TileBits-1:0] tile_t;

  typedef struct packed {
    tile_t tile_top;
    tile_t tile_mid;
    tile_t tile_bottom;
    logic  row_start;
  } cls_in_t;

  typedef struct packed {
    tile_t new_tile;
    tile_t old_tile;
    logic  changed;
  } cls_out_t;

endpackage

`default_nettype wire

FILE: design/colour_life_stencil_step.sv
// ----------------------------------------------------------------------------
// colour_life_stencil_step
// Colored Life (B3/S23) step over a streamed 3x3 tile window.
// ----------------------------------------------------------------------------
// One column of three tiles is taken per transfer, one per cycle. The two
// previous columns are held as the left and center of the window; with both
// held, each column gives one result for the window center in the cycle after
// its transfer, from a single output register. A set row_start clears the
// window and that column gives no result, nor does the column after it.
// Throughput is one column per cycle, limited only by the output
// register draining.
`default_nettype none

module colour_life_stencil_step
  import cls_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire cls_in_t  in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output cls_out_t      out_data_o
);

  tile_t                left_q   [3];
  tile_t                centre_q [3];
  logic  [FillBits-1:0] fill_q, fill_d;
  logic                 out_valid_q, out_valid_d;
  cls_out_t             out_q, out_d;

  logic                 in_xfer;
  logic                 out_xfer;
  logic                 emit;
  tile_t                nb  [8];
  tile_t                lw  [3];
  tile_t                cw  [3];
  logic  [CntBits-1:0]  live;
  logic  [SumBits-1:0]  sum;
  logic  [SumBits+RecipBits-1:0] prod;
  tile_t                avg;
  tile_t                centre;
  tile_t                nxt;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_xfer   = out_valid_q && !out_stall_i;

  // window as seen by this column, after an optional row restart
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lw[i] = in_data_i.row_start ? '0 : left_q[i];
      cw[i] = in_data_i.row_start ? '0 : centre_q[i];
    end
  end

  assign emit = !in_data_i.row_start && (fill_q == FillFull);

  always_comb begin
    nb[0] = lw[0];
    nb[1] = lw[1];
    nb[2] = lw[2];
    nb[3] = cw[0];
    nb[4] = cw[2];
    nb[5] = in_data_i.tile_top;
    nb[6] = in_data_i.tile_mid;
    nb[7] = in_data_i.tile_bottom;
    live = '0;
    sum  = '0;
    for (int i = 0; i < 8; i++) begin
      live = live + CntBits'(nb[i] != '0);
      sum  = sum + SumBits'(nb[i]);
    end
  end

  assign prod   = SumBits'(sum) * Recip3;
  assign avg    = TileBits'(prod >> SumBits);
  assign centre = cw[1];

  always_comb begin
    if (centre != '0) begin
      nxt = (live == CntBits'(2) || live == CntBits'(3)) ? centre : '0;
    end else if (live == CntBits'(3)) begin
      nxt = avg;
    end else begin
      nxt = '0;
    end
  end

  always_comb begin
    fill_d      = fill_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_xfer) begin
      out_valid_d = 1'b0;
    end
    if (in_xfer) begin
      if (in_data_i.row_start) begin
        fill_d = FillBits'(1);
      end else if (fill_q != FillFull) begin
        fill_d = fill_q + FillBits'(1);
      end
      if (emit) begin
        out_valid_d      = 1'b1;
        out_d.new_tile   = nxt;
        out_d.old_tile   = centre;
        out_d.changed    = (nxt != centre);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        left_q[i]   <= '0;
        centre_q[i] <= '0;
      end
    end else begin
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
      if (in_xfer) begin
        for (int i = 0; i < 3; i++) begin
          left_q[i] <= cw[i];
        end
        centre_q[0] <= in_data_i.tile_top;
        centre_q[1] <= in_data_i.tile_mid;
        centre_q[2] <= in_data_i.tile_bottom;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q != FillBits'(3))
    else $error("fill count out of range");

  a_new_result_from_xfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && emit) |=> out_valid_q)
    else $error("result lost");

  a_restart_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && in_data_i.row_start) |=> (fill_q == FillBits'(1)))
    else $error("row restart did not reset fill");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_q && !(in_xfer && emit)) |=> !out_valid_q)
    else $error("result without a transfer");

  a_changed_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.changed == (out_q.new_tile != out_q.old_tile)))
    else $error("changed flag mismatch");

endmodule

`default_nettype wire

FILE: dv/colour_life_stencil_step_check.sv
// ----------------------------------------------------------------------------
// colour_life_stencil_step_check
// Scoreboard for the colored Life stencil step.
// ----------------------------------------------------------------------------
// Watches both channels. Each column transfer updates a local copy of the
// 3x3 window and, once two columns are held, queues the expected center
// result. Each result transfer is compared field by field with the oldest
// queued result.
`default_nettype none

module colour_life_stencil_step_check
  import cls_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  cls_in_t     in_data_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  cls_out_t    out_data_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned checked_o
);

  typedef logic [2:0][TileBits-1:0] column_t;

  column_t          left_col;
  column_t          centre_col;
  logic [FillBits-1:0] cols_held;
  cls_out_t         expected_tiles[$];

  assign pending_o = expected_tiles.size();

  // B3/S23 with birth color = truncated mean of the three live neighbors
  function automatic tile_t life_next(column_t lcol, column_t ccol, column_t rcol);
    int unsigned live;
    int unsigned total;
    live  = 0;
    total = 0;
    for (int i = 0; i < 3; i++) begin
      live  += (lcol[i] != '0) + (rcol[i] != '0);
      total += lcol[i] + rcol[i];
    end
    live  += (ccol[0] != '0) + (ccol[2] != '0);
    total += ccol[0] + ccol[2];
    if (ccol[1] != '0) begin
      return (live == 2 || live == 3) ? ccol[1] : tile_t'(0);
    end
    if (live == 3) begin
      return tile_t'(total / 3);
    end
    return tile_t'(0);
  endfunction

  task automatic report(input string what, input int unsigned got, input int unsigned want);
    $display("mismatch: %s got %0d want %0d", what, got, want);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    column_t  rcol;
    cls_out_t exp_res;
    if (!rst_ni) begin
      left_col   = '0;
      centre_col = '0;
      cols_held  = '0;
      expected_tiles.delete();
      fail_count_o = 0;
      checked_o    = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_tiles.size() == 0) begin
          report("unexpected result transfer, new_tile", out_data_i.new_tile, 0);
        end else begin
          exp_res = expected_tiles.pop_front();
          checked_o++;
          if (out_data_i.new_tile !== exp_res.new_tile)
            report("new_tile", out_data_i.new_tile, exp_res.new_tile);
          if (out_data_i.old_tile !== exp_res.old_tile)
            report("old_tile", out_data_i.old_tile, exp_res.old_tile);
          if (out_data_i.changed !== exp_res.changed)
            report("changed", out_data_i.changed, exp_res.changed);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        rcol[0] = in_data_i.tile_top;
        rcol[1] = in_data_i.tile_mid;
        rcol[2] = in_data_i.tile_bottom;
        if (in_data_i.row_start) begin
          left_col   = '0;
          centre_col = '0;
          cols_held  = '0;
        end
        if (cols_held == FillFull) begin
          exp_res.old_tile = centre_col[1];
          exp_res.new_tile = life_next(left_col, centre_col, rcol);
          exp_res.changed  = exp_res.new_tile != exp_res.old_tile;
          expected_tiles.push_back(exp_res);
        end
        left_col   = centre_col;
        centre_col = rcol;
        if (cols_held != FillFull) cols_held++;
      end
    end
  end

endmodule

`default_nettype wire

FILE: dv/colour_life_stencil_step_test.sv
// ----------------------------------------------------------------------------
// colour_life_stencil_step_test
// Testbench top for the colored Life stencil step.
// ----------------------------------------------------------------------------
// Streams tile columns into the block: a directed set of births, survivals,
// deaths, color extremes and row restarts, then random rows of varying
// density with occasional stray row restarts. Runs under several mixes of
// sender idling and receiver stalls; the checker scores every result.
`default_nettype none

module colour_life_stencil_step_test;
  import cls_pkg::*;

  localparam int unsigned ColsPerPhase = 230;
  localparam int unsigned CycleLimit   = 200000;
  localparam int unsigned DrainCycles  = 8;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  cls_in_t     in_data;
  logic        out_valid;
  logic        out_stall;
  cls_out_t    out_data;
  logic        in_took;
  int unsigned cycle_count = 0;
  int unsigned idle_pct;
  int unsigned stall_pct;
  int unsigned cols_sent;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;

  colour_life_stencil_step dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  colour_life_stencil_step_check check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_took <= 1'b0;
    end else begin
      in_took <= in_valid && !in_stall;
    end
  end

  always @(negedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  function automatic tile_t rand_tile(input int unsigned dead_pct);
    int unsigned r;
    r = $urandom_range(99);
    if (r < dead_pct) return tile_t'(0);
    r = $urandom_range(9);
    if (r < 2) return tile_t'(255);
    if (r < 3) return tile_t'(1);
    return tile_t'($urandom_range(1, 255));
  endfunction

  // entered and left at a falling edge
  task automatic send_col(input tile_t t, input tile_t m, input tile_t b, input logic rs);
    cls_in_t col;
    col.tile_top    = t;
    col.tile_mid    = m;
    col.tile_bottom = b;
    col.row_start   = rs;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      in_data  <= cls_in_t'({$urandom, $urandom});
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= col;
    do @(negedge clk); while (!in_took);
    cols_sent++;
  endtask

  task automatic random_rows(input int unsigned n_cols);
    int unsigned row_len;
    int unsigned dead_pct;
    int unsigned sent;
    logic        rs;
    sent = 0;
    while (sent < n_cols) begin
      row_len  = ($urandom_range(9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 14);
      dead_pct = 40 + 15 * $urandom_range(2);
      for (int unsigned k = 0; k < row_len && sent < n_cols; k++) begin
        rs = (k == 0) || ($urandom_range(99) < 4);
        send_col(rand_tile(dead_pct), rand_tile(dead_pct), rand_tile(dead_pct), rs);
        sent++;
      end
    end
  endtask

  initial begin
    in_valid  = 1'b0;
    in_data   = '0;
    idle_pct  = 0;
    stall_pct = 0;
    cols_sent = 0;
    rst_n     = 1'b0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    // birth, truncated mean 21/3
    send_col(5, 0, 0, 1);   send_col(0, 0, 7, 0);     send_col(9, 0, 0, 0);
    send_col(0, 0, 0, 0);
    // birth at full color
    send_col(255, 0, 0, 1); send_col(255, 0, 0, 0);   send_col(255, 0, 0, 0);
    // survival with two neighbors
    send_col(1, 0, 0, 1);   send_col(0, 200, 0, 0);   send_col(0, 0, 1, 0);
    // survival with three neighbors
    send_col(1, 0, 1, 1);   send_col(0, 255, 0, 0);   send_col(0, 0, 1, 0);
    // lone tile dies
    send_col(0, 0, 0, 1);   send_col(0, 128, 0, 0);   send_col(0, 3, 0, 0);
    // overcrowded tile dies
    send_col(255, 255, 255, 1); send_col(255, 1, 255, 0); send_col(255, 255, 255, 0);
    // four neighbors, dead stays dead
    send_col(1, 1, 1, 1);   send_col(1, 0, 0, 0);     send_col(0, 0, 0, 0);
    // back-to-back restarts
    send_col(1, 2, 3, 1);   send_col(4, 5, 6, 1);     send_col(0, 0, 0, 0);
    send_col(7, 8, 9, 0);

    random_rows(ColsPerPhase);
    idle_pct = 81; stall_pct = 0;
    random_rows(ColsPerPhase);
    idle_pct = 0;  stall_pct = 81;
    random_rows(ColsPerPhase);
    idle_pct = 27; stall_pct = 27;
    random_rows(ColsPerPhase);

    in_valid <= 1'b0;
    stall_pct = 0;
    while (pending != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);

    $display("Sent %0d columns (directed Life cases, then random rows) under four idle/stall mixes",
             cols_sent);
    $display("Compared %0d center results, %0d mismatches", checked, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    wait (cycle_count >= CycleLimit);
    $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

`default_nettype wire
